@@ rtl/cde_pkg.sv @@
// cde_pkg: shared types, constants and pseudo-float helpers for the chi density evaluator.
// Used by every file in rtl/ except cde_if.sv; depends on nothing.
package cde_pkg;

  localparam int KAPPA_MAX = 32;
  localparam int NMUL_W    = $clog2(KAPPA_MAX);
  localparam int NMUL_CELLS = KAPPA_MAX - 1;

  localparam int EXP_W     = 13;
  localparam int EXP_TERMS = 12;
  localparam int TERM_W    = 4;
  localparam int NDIV      = 8;
  localparam int N_W       = 8;
  localparam int T_W       = 39;

  localparam logic [31:0] LN2Q    = 32'hB17217F8;
  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

  // reciprocal multipliers floor(2^S/i), S = 32 + clog2(i)
  localparam logic [32:0] RECIP_M [EXP_TERMS+1] = '{
    33'd0,          33'd4294967296, 33'd4294967296, 33'd5726623061,
    33'd4294967296, 33'd6871947673, 33'd5726623061, 33'd4908534052,
    33'd4294967296, 33'd7635497415, 33'd6871947673, 33'd6247225157,
    33'd5726623061
  };
  localparam logic [5:0] RECIP_S [EXP_TERMS+1] = '{
    6'd32, 6'd32, 6'd33, 6'd34, 6'd34, 6'd35, 6'd35,
    6'd35, 6'd35, 6'd36, 6'd36, 6'd36, 6'd36
  };

  typedef logic signed [EXP_W-1:0] exp_t;

  typedef enum logic [1:0] {
    CFG_MINIMUM   = 2'd0,
    CFG_INV_SIGMA = 2'd1,
    CFG_KAPPA     = 2'd2,
    CFG_NORM      = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] minimum;
    logic [31:0] inv_sigma;
    logic [5:0]  kappa;
    logic [31:0] norm_factor;
  } cfg_t;

  typedef struct packed {
    logic        z;
    logic [31:0] m;
    exp_t        e;
  } pf_t;

  typedef struct packed {
    logic              below;
    logic              big;
    logic [NMUL_W-1:0] nmul;
    pf_t               x;
    pf_t               acc;
    logic [T_W-1:0]    rem;
    logic [N_W-1:0]    n;
    logic [32:0]       h;
    logic [31:0]       p;
    logic [31:0]       q;
  } item_t;

  function automatic logic [4:0] lzc32(input logic [31:0] v);
    logic [4:0] n;
    logic       found;
    n = '0;
    found = 1'b0;
    for (int b = 31; b >= 0; b--) begin
      if (!found) begin
        if (v[b]) found = 1'b1;
        else n = n + 5'd1;
      end
    end
    return n;
  endfunction

  function automatic pf_t pf_norm32(input logic [31:0] v, input exp_t e0);
    pf_t        r;
    logic [4:0] lz;
    lz  = lzc32(v);
    r.z = (v == 32'd0);
    r.m = v << lz;
    r.e = e0 - exp_t'(lz);
    return r;
  endfunction

  function automatic pf_t pf_mul(input pf_t a, input pf_t b);
    pf_t         r;
    logic [63:0] p;
    p   = 64'(a.m) * 64'(b.m);
    r.z = a.z | b.z;
    if (p[63]) begin
      r.m = p[63:32];
      r.e = a.e + b.e + exp_t'(32);
    end else begin
      r.m = p[62:31];
      r.e = a.e + b.e + exp_t'(31);
    end
    return r;
  endfunction

endpackage

@@ rtl/cde_if.sv @@
// cde_if: valid/ready stream interfaces for samples in and densities out.
// Depends on nothing.
interface cde_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample;
  modport source(output valid, output sample, input ready);
  modport sink(input valid, input sample, output ready);
endinterface

interface cde_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] density;
  logic        below_minimum;
  modport source(output valid, output density, output below_minimum, input ready);
  modport sink(input valid, input density, input below_minimum, output ready);
endinterface

@@ rtl/chi_density_evaluator_unit.sv @@
// chi_density_evaluator_unit: streaming chi density, norm * x^(k-1) * exp(-x^2/2).
// Sections from accept to result, all registered: front, divide, exp, power and back.
// Throughput one item per cycle; each pipeline stage stalls only when the one after it is full.
// Reset (rst_n low, synchronous) empties the pipeline and loads register defaults.
// Depends on cde_pkg, cde_if and the cde_* cell modules.
module chi_density_evaluator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  cde_in_if.sink      in_ch,
  cde_out_if.source   out_ch
);
  localparam int NDIV_OFS = 0;
  localparam int NEXP_OFS = cde_pkg::NDIV;
  localparam int NMUL_OFS = cde_pkg::NDIV + cde_pkg::EXP_TERMS;
  localparam int NL       = NMUL_OFS + cde_pkg::NMUL_CELLS;

  cde_pkg::cfg_t cfg_r;

  // link i feeds cell i; link NL feeds the back end
  logic           lk_valid [NL+1];
  logic           lk_ready [NL+1];
  cde_pkg::item_t lk_item  [NL+1];

  // configuration registers; write only while idle, which the block itself does not enforce
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.minimum     <= 32'd0;
      cfg_r.inv_sigma   <= 32'd65536;
      cfg_r.kappa       <= 6'd2;
      cfg_r.norm_factor <= 32'd65536;
    end else if (cfg_we) begin
      unique case (cde_pkg::cfg_idx_t'(cfg_index))
        cde_pkg::CFG_MINIMUM:   cfg_r.minimum     <= cfg_wdata;
        cde_pkg::CFG_INV_SIGMA: cfg_r.inv_sigma   <= cfg_wdata;
        cde_pkg::CFG_KAPPA:     cfg_r.kappa       <= cfg_wdata[5:0];
        cde_pkg::CFG_NORM:      cfg_r.norm_factor <= cfg_wdata;
      endcase
    end
  end

  // x = (sample - minimum) * inverse_sigma, t = x^2/2, normalized x and norm
  cde_front u_front (
    .clk, .rst_n, .cfg(cfg_r),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_sample(in_ch.sample),
    .out_valid(lk_valid[0]), .out_ready(lk_ready[0]), .out_item(lk_item[0])
  );

  // t = n*ln2 + r, quotient bits MSB first
  for (genvar k = 0; k < cde_pkg::NDIV; k++) begin : g_div
    cde_div_cell u_div (
      .clk, .rst_n, .bit_idx(3'(cde_pkg::NDIV - 1 - k)),
      .in_valid(lk_valid[NDIV_OFS+k]), .in_ready(lk_ready[NDIV_OFS+k]),
      .in_item(lk_item[NDIV_OFS+k]),
      .out_valid(lk_valid[NDIV_OFS+k+1]), .out_ready(lk_ready[NDIV_OFS+k+1]),
      .out_item(lk_item[NDIV_OFS+k+1])
    );
  end

  // exp(-r) by Horner, terms 12 down to 1
  for (genvar k = 0; k < cde_pkg::EXP_TERMS; k++) begin : g_exp
    cde_exp_cell u_exp (
      .clk, .rst_n, .term(cde_pkg::TERM_W'(cde_pkg::EXP_TERMS - k)),
      .in_valid(lk_valid[NEXP_OFS+k]), .in_ready(lk_ready[NEXP_OFS+k]),
      .in_item(lk_item[NEXP_OFS+k]),
      .out_valid(lk_valid[NEXP_OFS+k+1]), .out_ready(lk_ready[NEXP_OFS+k+1]),
      .out_item(lk_item[NEXP_OFS+k+1])
    );
  end

  // x^(k-1): cell j multiplies when j < k-1
  for (genvar k = 0; k < cde_pkg::NMUL_CELLS; k++) begin : g_mul
    cde_mul_cell u_mul (
      .clk, .rst_n, .idx(cde_pkg::NMUL_W'(k)),
      .in_valid(lk_valid[NMUL_OFS+k]), .in_ready(lk_ready[NMUL_OFS+k]),
      .in_item(lk_item[NMUL_OFS+k]),
      .out_valid(lk_valid[NMUL_OFS+k+1]), .out_ready(lk_ready[NMUL_OFS+k+1]),
      .out_item(lk_item[NMUL_OFS+k+1])
    );
  end

  // final product with exp part, rounding, output register
  cde_back u_back (
    .clk, .rst_n,
    .in_valid(lk_valid[NL]), .in_ready(lk_ready[NL]), .in_item(lk_item[NL]),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_density(out_ch.density), .out_below(out_ch.below_minimum)
  );

  // a flagged sample never carries a density
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.below_minimum |-> out_ch.density == 32'd0)
    else $error("below_minimum item with nonzero density");

  // a ready sink lets the whole chain move
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.ready |-> in_ch.ready)
    else $error("input stalled while output is ready");

  assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

  assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && cfg_index == cde_pkg::CFG_KAPPA |=> cfg_r.kappa == $past(cfg_wdata[5:0]))
    else $error("kappa write lost");
endmodule

@@ rtl/cde_front.sv @@
// cde_front: offset, scale, square and normalize a sample (three stages).
// Depends on cde_pkg.
module cde_front (
  input  logic                clk,
  input  logic                rst_n,
  input  cde_pkg::cfg_t       cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [31:0]         in_sample,
  output logic                out_valid,
  input  logic                out_ready,
  output cde_pkg::item_t      out_item
);
  logic va_r, vb_r, vc_r;
  logic lda, ldb, ldc;

  logic [31:0]                 d_r, d_nxt;
  logic                        bel_a_r, bel_a_nxt, bel_b_r;
  logic [cde_pkg::NMUL_W-1:0]  nmul_a_r, nmul_a_nxt, nmul_b_r;
  logic [63:0]                 xw_r, xw_nxt;
  cde_pkg::item_t              item_r, item_nxt;

  logic [32:0] dfull;
  logic [6:0]  kc;
  logic [31:0] xv;
  logic [63:0] xx;

  assign ldc      = !vc_r || out_ready;
  assign ldb      = !vb_r || ldc;
  assign lda      = !va_r || ldb;
  assign in_ready = lda;

  always_comb begin
    dfull     = {in_sample[31], in_sample} - {cfg.minimum[31], cfg.minimum};
    bel_a_nxt = dfull[32];
    d_nxt     = dfull[31:0];
    if (cfg.kappa == 6'd0) begin
      kc = 7'd1;
    end else if ({1'b0, cfg.kappa} > 7'(cde_pkg::KAPPA_MAX)) begin
      kc = 7'(cde_pkg::KAPPA_MAX);
    end else begin
      kc = {1'b0, cfg.kappa};
    end
    nmul_a_nxt = cde_pkg::NMUL_W'(kc - 7'd1);
  end

  assign xw_nxt = 64'(d_r) * 64'(cfg.inv_sigma);

  always_comb begin
    xv             = xw_r[35:4];
    xx             = 64'(xv) * 64'(xv);
    item_nxt       = '0;
    item_nxt.below = bel_b_r;
    item_nxt.big   = |xw_r[63:36];
    item_nxt.nmul  = nmul_b_r;
    item_nxt.x     = cde_pkg::pf_norm32(xv, cde_pkg::exp_t'(-28));
    item_nxt.acc   = cde_pkg::pf_norm32(cfg.norm_factor, cde_pkg::exp_t'(-16));
    item_nxt.rem   = xx[63:25];
    item_nxt.h     = cde_pkg::ONE_Q32;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (lda) va_r <= in_valid;
      if (ldb) vb_r <= va_r;
      if (ldc) vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (lda) begin
      d_r      <= d_nxt;
      bel_a_r  <= bel_a_nxt;
      nmul_a_r <= nmul_a_nxt;
    end
    if (ldb) begin
      xw_r     <= xw_nxt;
      bel_b_r  <= bel_a_r;
      nmul_b_r <= nmul_a_r;
    end
    if (ldc) item_r <= item_nxt;
  end

  assign out_valid = vc_r;
  assign out_item  = item_r;
endmodule

@@ rtl/cde_div_cell.sv @@
// cde_div_cell: one restoring step of t / ln2, producing one quotient bit.
// Depends on cde_pkg.
module cde_div_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [2:0]     bit_idx,
  input  logic           in_valid,
  output logic           in_ready,
  input  cde_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output cde_pkg::item_t out_item
);
  logic           v_r, ld;
  cde_pkg::item_t item_r, item_nxt;
  logic [39:0]    cmp;

  assign ld       = !v_r || out_ready;
  assign in_ready = ld;

  always_comb begin
    item_nxt = in_item;
    cmp      = {8'd0, cde_pkg::LN2Q} << bit_idx;
    if ({1'b0, in_item.rem} >= cmp) begin
      item_nxt.rem          = cde_pkg::T_W'({1'b0, in_item.rem} - cmp);
      item_nxt.n[bit_idx]   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else if (ld) v_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (ld) item_r <= item_nxt;
  end

  assign out_valid = v_r;
  assign out_item  = item_r;
endmodule

@@ rtl/cde_exp_cell.sv @@
// cde_exp_cell: one Horner term h = 1 - (r*h)/i of exp(-r) (three stages).
// Depends on cde_pkg.
module cde_exp_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [cde_pkg::TERM_W-1:0] term,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  cde_pkg::item_t             in_item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output cde_pkg::item_t             out_item
);
  logic           va_r, vb_r, vc_r, lda, ldb, ldc;
  cde_pkg::item_t a_r, a_nxt, b_r, b_nxt, c_r, c_nxt;
  logic [64:0]    rh, pm;
  logic [35:0]    qi, chk;
  logic [31:0]    qq;

  assign ldc      = !vc_r || out_ready;
  assign ldb      = !vb_r || ldc;
  assign lda      = !va_r || ldb;
  assign in_ready = lda;

  always_comb begin
    a_nxt   = in_item;
    rh      = 65'(in_item.rem[31:0]) * 65'(in_item.h);
    a_nxt.p = rh[63:32];
  end

  always_comb begin
    b_nxt   = a_r;
    pm      = 65'(a_r.p) * 65'(cde_pkg::RECIP_M[term]);
    b_nxt.q = 32'(pm >> cde_pkg::RECIP_S[term]);
  end

  // reciprocal estimate is exact or one low
  always_comb begin
    c_nxt = b_r;
    qi    = 36'(b_r.q) * 36'(term);
    chk   = 36'(b_r.p) - qi;
    qq    = (chk >= 36'(term)) ? b_r.q + 32'd1 : b_r.q;
    c_nxt.h = cde_pkg::ONE_Q32 - 33'(qq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (lda) va_r <= in_valid;
      if (ldb) vb_r <= va_r;
      if (ldc) vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (lda) a_r <= a_nxt;
    if (ldb) b_r <= b_nxt;
    if (ldc) c_r <= c_nxt;
  end

  assign out_valid = vc_r;
  assign out_item  = c_r;
endmodule

@@ rtl/cde_mul_cell.sv @@
// cde_mul_cell: one power step acc = acc * x, active when its index is below nmul.
// Depends on cde_pkg.
module cde_mul_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [cde_pkg::NMUL_W-1:0] idx,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  cde_pkg::item_t             in_item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output cde_pkg::item_t             out_item
);
  logic           v_r, ld;
  cde_pkg::item_t item_r, item_nxt;

  assign ld       = !v_r || out_ready;
  assign in_ready = ld;

  always_comb begin
    item_nxt = in_item;
    if (in_item.nmul > idx) item_nxt.acc = cde_pkg::pf_mul(in_item.acc, in_item.x);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else if (ld) v_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (ld) item_r <= item_nxt;
  end

  assign out_valid = v_r;
  assign out_item  = item_r;
endmodule

@@ rtl/cde_back.sv @@
// cde_back: normalize exp part, final multiply, round to Q16.16 into the output register.
// Depends on cde_pkg.
module cde_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  cde_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    out_density,
  output logic           out_below
);
  logic           va_r, vb_r, vc_r, lda, ldb, ldc;
  cde_pkg::item_t a_r, a_nxt, b_r, b_nxt;
  logic [31:0]    dens_r, dens_nxt;
  logic           below_r;
  cde_pkg::exp_t  s;
  logic [5:0]     sh;
  logic [33:0]    rnd;

  assign ldc      = !vc_r || out_ready;
  assign ldb      = !vb_r || ldc;
  assign lda      = !va_r || ldb;
  assign in_ready = lda;

  // exp part h * 2^-(32+n); h lies in [1, 2^32]
  always_comb begin
    a_nxt = in_item;
    if (in_item.h[32]) begin
      a_nxt.x.z = 1'b0;
      a_nxt.x.m = 32'h8000_0000;
      a_nxt.x.e = cde_pkg::exp_t'(-31) - cde_pkg::exp_t'(in_item.n);
    end else begin
      a_nxt.x = cde_pkg::pf_norm32(in_item.h[31:0],
                  cde_pkg::exp_t'(-32) - cde_pkg::exp_t'(in_item.n));
    end
  end

  always_comb begin
    b_nxt     = a_r;
    b_nxt.acc = cde_pkg::pf_mul(a_r.acc, a_r.x);
  end

  always_comb begin
    s   = b_r.acc.e + cde_pkg::exp_t'(16);
    sh  = 6'(-s);
    rnd = '0;
    if (b_r.below || b_r.big || b_r.acc.z) begin
      dens_nxt = '0;
    end else if (s > cde_pkg::exp_t'(0)) begin
      dens_nxt = 32'hFFFF_FFFF;
    end else if (s == cde_pkg::exp_t'(0)) begin
      dens_nxt = b_r.acc.m;
    end else if (s <= cde_pkg::exp_t'(-34)) begin
      dens_nxt = '0;
    end else begin
      rnd      = (34'(b_r.acc.m) + (34'd1 << (sh - 6'd1))) >> sh;
      dens_nxt = rnd[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (lda) va_r <= in_valid;
      if (ldb) vb_r <= va_r;
      if (ldc) vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (lda) a_r <= a_nxt;
    if (ldb) b_r <= b_nxt;
    if (ldc) begin
      dens_r  <= dens_nxt;
      below_r <= b_r.below;
    end
  end

  assign out_valid   = vc_r;
  assign out_density = dens_r;
  assign out_below   = below_r;
endmodule

@@ tb/chi_density_evaluator_unit_tb.sv @@
// Self-checking bench for chi_density_evaluator_unit: random and directed samples over
// several register settings, each density predicted bit for bit and compared in order.
// Depends on cde_pkg, cde_if and the RTL of the unit.
module chi_density_evaluator_unit_tb;

  // pseudo-float: mantissa with top bit set (or zero) and a binary exponent
  typedef struct {
    longint unsigned m;
    int              e;
  } pflt_t;

  typedef struct {
    logic [31:0] density;
    logic        below;
  } density_t;

  // Keeps its own copy of the registers and a queue of predicted densities.
  class density_board;
    logic [31:0] minimum = 32'd0;
    logic [31:0] inv_sigma = 32'd65536;
    logic [5:0]  kappa = 6'd2;
    logic [31:0] norm_factor = 32'd65536;
    density_t    awaited[$];
    int          errors = 0;
    int          matched = 0;
    int          below_seen = 0;
    int          zero_seen = 0;

    function void set_reg(cde_pkg::cfg_idx_t idx, logic [31:0] v);
      case (idx)
        cde_pkg::CFG_MINIMUM:   minimum = v;
        cde_pkg::CFG_INV_SIGMA: inv_sigma = v;
        cde_pkg::CFG_KAPPA:     kappa = v[5:0];
        cde_pkg::CFG_NORM:      norm_factor = v;
      endcase
    endfunction

    function pflt_t pf_fix(longint unsigned m, int e);
      pflt_t r;
      r.m = 0;
      r.e = 0;
      if (m == 0) return r;
      while (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        e++;
      end
      while (m < 64'h8000_0000) begin
        m = m << 1;
        e--;
      end
      r.m = m;
      r.e = e;
      return r;
    endfunction

    function pflt_t pf_times(pflt_t a, pflt_t b);
      if (a.m == 0 || b.m == 0) return pf_fix(0, 0);
      return pf_fix(a.m * b.m, a.e + b.e);
    endfunction

    // round half up to Q16.16, saturate
    function logic [31:0] pf_q16(pflt_t a);
      int          s;
      int unsigned sh;
      if (a.m == 0) return 32'd0;
      s = a.e + 16;
      if (s > 0) return 32'hFFFF_FFFF;
      if (s == 0) return a.m[31:0];
      if (s <= -34) return 32'd0;
      sh = -s;
      return 32'((a.m + (64'd1 << (sh - 1))) >> sh);
    endfunction

    function void note_sample(logic signed [31:0] s);
      longint          d;
      longint unsigned xw, x, t, n, r, h, k;
      pflt_t           acc, xf, ef;
      density_t        p;
      d = longint'(s) - longint'($signed(minimum));
      p.below = 1'b0;
      p.density = 32'd0;
      if (d < 0) begin
        p.below = 1'b1;
      end else begin
        xw = longint'(d) * longint'(inv_sigma);
        if (xw < (64'd16 << 32)) begin
          x = xw >> 4;
          k = kappa;
          if (k == 0) k = 1;
          if (k > cde_pkg::KAPPA_MAX) k = cde_pkg::KAPPA_MAX;
          // exp(-x^2/2) by range reduction over ln 2 and a Horner series
          t = (x * x) >> 25;
          n = t / 64'(cde_pkg::LN2Q);
          r = t - n * 64'(cde_pkg::LN2Q);
          h = 64'h1_0000_0000;
          for (int i = cde_pkg::EXP_TERMS; i >= 1; i--)
            h = 64'h1_0000_0000 - (((r * h) >> 32) / i);
          acc = pf_fix(norm_factor, -16);
          xf = pf_fix(x, -28);
          for (int i = 1; i < k; i++) acc = pf_times(acc, xf);
          ef = pf_fix(h, -32 - int'(n));
          acc = pf_times(acc, ef);
          p.density = pf_q16(acc);
        end
      end
      awaited.push_back(p);
    endfunction

    task report(string what);
      errors++;
      $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    task check(logic [31:0] density, logic below);
      density_t p;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected item density=%h below=%b", density, below));
        return;
      end
      p = awaited.pop_front();
      if (density !== p.density)
        report($sformatf("density %h, predicted %h", density, p.density));
      if (below !== p.below)
        report($sformatf("below_minimum %b, predicted %b", below, p.below));
      if (density === p.density && below === p.below) matched++;
      if (p.below) below_seen++;
      else if (p.density == 0) zero_seen++;
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = cde_pkg::CFG_MINIMUM;
  logic [31:0] cfg_wdata = 32'd0;
  bit          quiet = 1'b0;   // no idling on either side while set
  int          sent = 0;

  cde_in_if  in_ch();
  cde_out_if out_ch();

  density_board board = new();

  chi_density_evaluator_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    out_ch.ready = 1'b0;
  end

  // Receiver: holds ready low with a chance of about 35 in a hundred unless quiet.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check(out_ch.density, out_ch.below_minimum);
    out_ch.ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 35);
  end

  // Offer one sample; valid stays up into the next call unless a gap is drawn.
  task push_sample(logic signed [31:0] s);
    in_ch.valid <= 1'b1;
    in_ch.sample <= s;
    do @(posedge clk); while (!in_ch.ready);
    board.note_sample(s);
    sent++;
    if (!quiet && $urandom_range(0, 99) < 35) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
  endtask

  // Wait until every predicted result has come out, then idle, before touching registers.
  task drain;
    in_ch.valid <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (90) @(posedge clk);
  endtask

  task write_regs(logic [31:0] mn, logic [31:0] inv, logic [31:0] kap, logic [31:0] nrm);
    logic [31:0] vals[4];
    vals = '{mn, inv, kap, nrm};
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= cde_pkg::cfg_idx_t'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
      board.set_reg(cde_pkg::cfg_idx_t'(i), vals[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Random samples: mostly x inside [0,16), some anywhere, some below minimum.
  task random_phase(int count);
    longint      lim, s, mn;
    logic [31:0] inv;
    int          pick;
    for (int i = 0; i < count; i++) begin
      mn = longint'($signed(board.minimum));
      inv = board.inv_sigma;
      pick = $urandom_range(0, 99);
      if (inv == 0) lim = 64'hFFFF_FFFF;
      else lim = ((64'd16 << 32) / inv) + 2;
      if (lim > 64'hFFFF_FFFF) lim = 64'hFFFF_FFFF;
      if (pick < 70) s = mn + longint'($urandom_range(0, 32'(lim)));
      else if (pick < 85) s = longint'($signed($urandom()));
      else s = mn - longint'($urandom_range(1, 32'h7FFF_FFFF));
      if (s > 64'sh7FFF_FFFF || s < -64'sh8000_0000) s = longint'($signed($urandom()));
      push_sample(32'(s));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed at reset values (minimum 0, 1/sigma 1.0, k 2, norm 1.0):
    // zero argument, below minimum, x exactly 16 and just under, field extremes.
    push_sample(32'sd0);
    push_sample(-32'sd1);
    push_sample(32'sh8000_0000);
    push_sample(32'sh7FFF_FFFF);
    push_sample(32'sh0001_0000);
    push_sample(32'sh0000_0001);
    push_sample(32'sh0010_0000);
    push_sample(32'sh000F_FFFF);
    push_sample(32'sh0002_8000);
    push_sample(32'sh0008_0000);
    push_sample(32'shFFFF_0000);
    push_sample(32'sh0000_8000);

    random_phase(200);

    // k = 1: density equals norm at x = 0
    write_regs(32'd0, 32'd65536, 32'd1, 32'd65536);
    push_sample(32'sd0);
    push_sample(32'sh0000_4000);
    random_phase(200);

    // lowest minimum, largest 1/sigma, k at its ceiling, largest norm
    write_regs(32'h8000_0000, 32'hFFFF_FFFF, 32'd32, 32'hFFFF_FFFF);
    push_sample(32'sh8000_0000);
    push_sample(32'sh8000_0001);
    push_sample(32'sh7FFF_FFFF);
    random_phase(200);

    // highest minimum, smallest nonzero 1/sigma, kappa above ceiling (clamped)
    write_regs(32'h7FFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd1);
    push_sample(32'sh7FFF_FFFF);
    push_sample(32'sh7FFF_FFFE);
    random_phase(200);

    // zero 1/sigma makes x zero; kappa zero acts as k = 1; upper data bits dropped
    write_regs(32'h0001_0000, 32'd0, 32'hABCD_EF40, 32'h0001_2345);
    random_phase(200);

    // zero norm
    write_regs(32'hFFFF_8000, 32'h0002_0000, 32'd5, 32'd0);
    random_phase(200);

    // long stretch with no idling on either side
    quiet = 1'b1;
    write_regs(32'hFFFB_0000, 32'h0000_8000, 32'd3, 32'h0003_0000);
    random_phase(220);
    quiet = 1'b0;

    for (int ph = 0; ph < 3; ph++) begin
      write_regs($urandom() >> $urandom_range(0, 31) ^ {32{$urandom_range(0, 1) == 1}},
                 $urandom() >> $urandom_range(0, 24), $urandom(),
                 $urandom() >> $urandom_range(0, 24));
      random_phase(110);
    end

    in_ch.valid <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Ran %0d samples over 10 register settings: %0d below minimum, %0d zero densities.",
             sent, board.below_seen, board.zero_seen);
    $display("%0d results matched, %0d mismatches.", board.matched, board.errors);
    if (board.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #(12 * 2_000_000);
    $display("Timeout with %0d results outstanding.", board.awaited.size());
    $display("TEST FAILED");
    $finish;
  end
endmodule

@@ files.f @@
rtl/cde_pkg.sv
rtl/cde_if.sv
rtl/cde_front.sv
rtl/cde_div_cell.sv
rtl/cde_exp_cell.sv
rtl/cde_mul_cell.sv
rtl/cde_back.sv
rtl/chi_density_evaluator_unit.sv
tb/chi_density_evaluator_unit_tb.sv
